[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RC4 cipher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, register indexes, controller states and the command and
// status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_ADDR_W   = $clog2(PERM_DEPTH);
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KIDX_W        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_RD_N,
        ST_K_RD_A,
        ST_K_WR1,
        ST_K_WR2,
        ST_P_RD_I,
        ST_P_RD_J,
        ST_P_WR1,
        ST_P_WR2,
        ST_P_RD_K,
        ST_P_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_SCHED_START,
        DP_FILL,
        DP_K_RD_N,
        DP_K_RD_A,
        DP_K_WR1,
        DP_K_WR2,
        DP_P_RD_I,
        DP_P_RD_J,
        DP_P_WR1,
        DP_P_WR2,
        DP_P_RD_K,
        DP_P_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load_in;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic count_last;
        logic out_busy;
    } dp_status_t;

endpackage

[sv/rc4_ram.sv]
// ----------------------------------------------------------------------------
// RC4 RAM
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    assign rd = rd_reg;

endmodule

[sv/rc4_dp.sv]
// ----------------------------------------------------------------------------
// RC4 datapath
// Key registers, indices, permutation memory and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rc4_pkg::dp_cmd_t                cmd,
    output rc4_pkg::dp_status_t             status,
    input  logic [rc4_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            cfg_valid,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]       cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]      out_byte
);

    import rc4_pkg::*;

    logic [KEY_W-1:0]       key_low_reg;
    logic [KEY_W-1:0]       key_high_reg;
    logic [LEN_W-1:0]       key_len_reg;
    logic [BYTE_W-1:0]      data_reg;
    logic [PERM_ADDR_W-1:0] n_reg;
    logic [PERM_ADDR_W-1:0] n_next;
    logic [BYTE_W-1:0]      acc_reg;
    logic [BYTE_W-1:0]      acc_next;
    logic [KIDX_W-1:0]      kidx_reg;
    logic [KIDX_W-1:0]      kidx_next;
    logic [BYTE_W-1:0]      i_reg;
    logic [BYTE_W-1:0]      i_next;
    logic [BYTE_W-1:0]      j_reg;
    logic [BYTE_W-1:0]      j_next;
    logic [BYTE_W-1:0]      si_reg;
    logic [BYTE_W-1:0]      si_next;
    logic [BYTE_W-1:0]      sj_reg;
    logic [BYTE_W-1:0]      sj_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   out_valid_reg;

    logic [2*KEY_W-1:0]     key_bytes;
    logic [BYTE_W-1:0]      key_byte;
    logic [LEN_W-1:0]       eff_len;
    logic                   kidx_last;

    logic                   ram_we;
    logic [PERM_ADDR_W-1:0] ram_wa;
    logic [BYTE_W-1:0]      ram_wd;
    logic                   ram_re;
    logic [PERM_ADDR_W-1:0] ram_ra;
    logic [BYTE_W-1:0]      ram_rd;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .clk (clk),
        .we  (ram_we),
        .wa  (ram_wa),
        .wd  (ram_wd),
        .re  (ram_re),
        .ra  (ram_ra),
        .rd  (ram_rd)
    );

    assign key_bytes = {key_high_reg, key_low_reg};
    assign key_byte  = key_bytes[{kidx_reg, 3'b000} +: BYTE_W];

    always_comb
    begin
        priority if (key_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (key_len_reg > LEN_W'(MAX_KEY_BYTES))
        begin
            eff_len = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    assign kidx_last = ({1'b0, kidx_reg} == (eff_len - LEN_W'(1)));

    always_comb
    begin
        n_next    = n_reg;
        acc_next  = acc_reg;
        kidx_next = kidx_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        si_next   = si_reg;
        sj_next   = sj_reg;
        ram_we    = 1'b0;
        ram_wa    = n_reg;
        ram_wd    = ram_rd;
        ram_re    = 1'b0;
        ram_ra    = n_reg;
        unique case (cmd.op)
            DP_NOP:
            begin
            end
            DP_SCHED_START:
            begin
                n_next    = '0;
                acc_next  = '0;
                kidx_next = '0;
                i_next    = '0;
                j_next    = '0;
            end
            DP_FILL:
            begin
                ram_we = 1'b1;
                ram_wa = n_reg;
                ram_wd = BYTE_W'(n_reg);
                n_next = n_reg + PERM_ADDR_W'(1);
            end
            DP_K_RD_N:
            begin
                ram_re = 1'b1;
                ram_ra = n_reg;
            end
            DP_K_RD_A:
            begin
                acc_next = acc_reg + ram_rd + key_byte;
                si_next  = ram_rd;
                ram_re   = 1'b1;
                ram_ra   = acc_next;
            end
            DP_K_WR1:
            begin
                ram_we = 1'b1;
                ram_wa = n_reg;
                ram_wd = ram_rd;
            end
            DP_K_WR2:
            begin
                ram_we    = 1'b1;
                ram_wa    = acc_reg;
                ram_wd    = si_reg;
                n_next    = n_reg + PERM_ADDR_W'(1);
                kidx_next = kidx_last ? '0 : kidx_reg + KIDX_W'(1);
            end
            DP_P_RD_I:
            begin
                i_next = i_reg + BYTE_W'(1);
                ram_re = 1'b1;
                ram_ra = i_next;
            end
            DP_P_RD_J:
            begin
                j_next  = j_reg + ram_rd;
                si_next = ram_rd;
                ram_re  = 1'b1;
                ram_ra  = j_next;
            end
            DP_P_WR1:
            begin
                sj_next = ram_rd;
                ram_we  = 1'b1;
                ram_wa  = i_reg;
                ram_wd  = ram_rd;
            end
            DP_P_WR2:
            begin
                ram_we = 1'b1;
                ram_wa = j_reg;
                ram_wd = si_reg;
            end
            DP_P_RD_K:
            begin
                ram_re = 1'b1;
                ram_ra = si_reg + sj_reg;
            end
            DP_P_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            key_len_reg   <= LEN_W'(1);
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LEN:  key_len_reg  <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == DP_P_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            data_reg <= data_byte;
        end
        if (cmd.op == DP_P_OUT)
        begin
            out_byte_reg <= data_reg ^ ram_rd;
        end
        n_reg    <= n_next;
        acc_reg  <= acc_next;
        kidx_reg <= kidx_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
    end

    assign status.count_last = (n_reg == PERM_ADDR_W'(PERM_DEPTH - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;

    `ASSERT_IMPLY(a_no_rw_same_addr, clk, rst_n, ram_we && ram_re, ram_wa != ram_ra)
    `ASSERT_IMPLY(a_out_load_free, clk, rst_n, cmd.op == DP_P_OUT,
                  !(out_valid_reg && !out_ready))

endmodule

[sv/rc4_ctrl.sv]
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the key schedule and the per-byte keystream steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 new_message,
    input  rc4_pkg::dp_status_t  status,
    output rc4_pkg::dp_cmd_t     cmd
);

    import rc4_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        keyed_reg;
    logic        keyed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            keyed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            keyed_reg <= keyed_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        keyed_next  = keyed_reg;
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.op      = DP_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (new_message || !keyed_reg)
                    begin
                        cmd.op     = DP_SCHED_START;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_P_RD_I;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.op = DP_FILL;
                if (status.count_last)
                begin
                    state_next = ST_K_RD_N;
                end
            end
            ST_K_RD_N:
            begin
                cmd.op     = DP_K_RD_N;
                state_next = ST_K_RD_A;
            end
            ST_K_RD_A:
            begin
                cmd.op     = DP_K_RD_A;
                state_next = ST_K_WR1;
            end
            ST_K_WR1:
            begin
                cmd.op     = DP_K_WR1;
                state_next = ST_K_WR2;
            end
            ST_K_WR2:
            begin
                cmd.op = DP_K_WR2;
                if (status.count_last)
                begin
                    keyed_next = 1'b1;
                    state_next = ST_P_RD_I;
                end
                else
                begin
                    state_next = ST_K_RD_N;
                end
            end
            ST_P_RD_I:
            begin
                cmd.op     = DP_P_RD_I;
                state_next = ST_P_RD_J;
            end
            ST_P_RD_J:
            begin
                cmd.op     = DP_P_RD_J;
                state_next = ST_P_WR1;
            end
            ST_P_WR1:
            begin
                cmd.op     = DP_P_WR1;
                state_next = ST_P_WR2;
            end
            ST_P_WR2:
            begin
                cmd.op     = DP_P_WR2;
                state_next = ST_P_RD_K;
            end
            ST_P_RD_K:
            begin
                cmd.op     = DP_P_RD_K;
                state_next = ST_P_OUT;
            end
            ST_P_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = DP_P_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_first_byte_keys, clk, rst_n, in_valid && in_ready && !keyed_reg,
                 state_reg == ST_FILL)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

[sv/rc4_stream_cipher.sv]
// ----------------------------------------------------------------------------
// RC4 stream cipher
// XORs each data byte with the next RC4 keystream byte.
// ----------------------------------------------------------------------------
// The block handles one byte at a time, taking it in the idle state. It then
// runs six steps in the single permutation memory (read S[i], read S[j], two
// swap writes, read S[S[i]+S[j]], output load); the output load waits while
// an earlier result is still held. The first byte after reset and every byte
// marked new_message first run the key schedule, which fills the permutation
// and then makes 256 swaps, each a read of S[n], a read of S[acc] and two
// swap writes. The result register frees the input side, so the next byte is
// taken while a result still waits on the output. The user must write key
// registers through the configuration channel only while the block is idle,
// which the block does not enforce; they take effect at the next key schedule.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            new_message,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]      out_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]       cfg_data
);

    import rc4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rc4_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_message (new_message),
        .status      (status),
        .cmd         (cmd)
    );

    rc4_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte)
    );

endmodule

[bench/tb_rc4_stream_cipher.sv]
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives bytes through the cipher with random idle cycles on both sides and
// checks every output byte against an in-bench keystream generator. Each
// phase runs with its own key and key length, including the zero, saturated
// and out-of-range settings. Register writes happen only when the block is
// idle, sometimes in the middle of a message.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher;
    import rc4_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class keystream_scoreboard;
        bit [KEY_W-1:0]  key_low = '0;
        bit [KEY_W-1:0]  key_high = '0;
        bit [LEN_W-1:0]  key_len = LEN_W'(1);
        bit [BYTE_W-1:0] perm [PERM_DEPTH];
        bit [BYTE_W-1:0] idx_i = '0;
        bit [BYTE_W-1:0] idx_j = '0;
        bit              keyed = 1'b0;
        bit [BYTE_W-1:0] expected_bytes [$];
        int              errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
            case (idx)
                CFG_KEY_LOW:  key_low = value;
                CFG_KEY_HIGH: key_high = value;
                CFG_KEY_LEN:  key_len = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [BYTE_W-1:0] data, logic restart);
            int              len;
            int              k;
            bit [BYTE_W-1:0] acc;
            bit [BYTE_W-1:0] kb;
            bit [BYTE_W-1:0] t;
            bit [BYTE_W-1:0] sum;
            if (restart || !keyed)
            begin
                len = key_len;
                if (len == 0)
                    len = 1;
                if (len > MAX_KEY_BYTES)
                    len = MAX_KEY_BYTES;
                for (int n = 0; n < PERM_DEPTH; n++)
                    perm[n] = BYTE_W'(n);
                acc = '0;
                for (int n = 0; n < PERM_DEPTH; n++)
                begin
                    k = n % len;
                    kb = (k < 8) ? key_low[8*k +: 8] : key_high[8*(k-8) +: 8];
                    acc = acc + perm[n] + kb;
                    t = perm[n];
                    perm[n] = perm[acc];
                    perm[acc] = t;
                end
                idx_i = '0;
                idx_j = '0;
                keyed = 1'b1;
            end
            idx_i = idx_i + 1'b1;
            idx_j = idx_j + perm[idx_i];
            t = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum = perm[idx_i] + perm[idx_j];
            expected_bytes.push_back(data ^ perm[sum]);
        endfunction

        function void check_byte(logic [BYTE_W-1:0] actual);
            bit [BYTE_W-1:0] want;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $error("out_byte unexpected: expected none, actual %02h", actual);
                return;
            end
            want = expected_bytes.pop_front();
            if (actual !== want)
            begin
                errors++;
                $error("out_byte mismatch: expected %02h, actual %02h", want, actual);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte;
    logic                 new_message;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    out_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;
    logic                 quiet;

    keystream_scoreboard keystream = new();

    rc4_stream_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .new_message (new_message),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                keystream.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                keystream.note_byte(data_byte, new_message);
            if (out_valid && out_ready)
                keystream.check_byte(out_byte);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic restart);
        while (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= data;
        new_message <= restart;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (keystream.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int   total;
        int   seg;
        int   count;
        logic restart;
        in_valid    <= 1'b0;
        data_byte   <= '0;
        new_message <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_KEY_LOW;
        cfg_data    <= '0;
        quiet       <= 1'b0;
        rst_n       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first byte after reset must key the block even without new_message.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        drain();

        write_config(CFG_KEY_LOW, '1);
        write_config(CFG_KEY_HIGH, '1);
        write_config(CFG_KEY_LEN, 64'd16);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        drain();

        write_config(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_config(CFG_KEY_LEN, 64'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h81, 1'b1);
        drain();

        write_config(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        write_config(CFG_KEY_LEN, 64'hFFFF_FFFF_FFFF_FFF1);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        drain();

        // New key written mid-message: the running keystream must not change.
        write_config(CFG_KEY_LEN, 64'd31);
        write_config(CFG_KEY_LOW, '0);
        write_config(CFG_UNUSED, '1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b1);
        drain();

        write_config(CFG_KEY_LEN, 64'd1);
        write_config(CFG_KEY_LOW, 64'h0000_0000_0000_00FF);
        send_byte(8'h10, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h42, 1'b0);

        total = 0;
        seg = 0;
        while (total < 700)
        begin
            drain();
            quiet <= (seg == 4);
            write_config(CFG_KEY_LOW, {$urandom, $urandom});
            write_config(CFG_KEY_HIGH, {$urandom, $urandom});
            if ($urandom_range(9) == 0)
                write_config(CFG_KEY_LEN, {$urandom, 27'd0, 5'($urandom_range(31))});
            else
                write_config(CFG_KEY_LEN, 64'($urandom_range(16, 1)));
            if ($urandom_range(7) == 0)
                write_config(CFG_UNUSED, {$urandom, $urandom});
            count = $urandom_range(80, 20);
            for (int k = 0; k < count; k++)
            begin
                restart = ((k == 0) && ($urandom_range(5) != 0)) || ($urandom_range(24) == 0);
                send_byte(8'($urandom_range(255)), restart);
            end
            total += count;
            seg++;
        end

        drain();
        repeat (40) @(posedge clk);
        if (keystream.errors == 0 && keystream.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
